>>> src/iisp_pkg.sv
package iisp_pkg;

  // Widths of the position counter and the region offset.
  localparam int unsigned PosW = 23;
  localparam int unsigned OfsW = 22;
  localparam int unsigned RamW = 14;

  // Image layout constants.
  localparam logic [PosW-1:0] HdrLen     = 23'd16;
  localparam logic [PosW-1:0] TrainerLen = 23'd512;
  localparam logic [PosW-1:0] PosMax     = {PosW{1'b1}};
  localparam logic [RamW-1:0] RamSize    = 14'h2000;

  // Header byte positions that are latched.
  localparam logic [PosW-1:0] PosPrgBanks = 23'd4;
  localparam logic [PosW-1:0] PosChrBanks = 23'd5;
  localparam logic [PosW-1:0] PosFlags6   = 23'd6;
  localparam logic [PosW-1:0] PosMagicEnd = 23'd4;

  // Bit positions inside flags byte six.
  localparam int unsigned FlagVertical   = 0;
  localparam int unsigned FlagBattery    = 1;
  localparam int unsigned FlagTrainer    = 2;
  localparam int unsigned FlagFourScreen = 3;

  localparam logic [3:0] MapperMmc1 = 4'd1;

  // Magic bytes: "NES" followed by 0x1A.
  localparam logic [7:0] Magic [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

  typedef enum logic [2:0] {
    REGION_HEADER    = 3'd0,
    REGION_TRAINER   = 3'd1,
    REGION_PROGRAM   = 3'd2,
    REGION_CHARACTER = 3'd3,
    REGION_EXCESS    = 3'd4
  } region_e;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_MAGIC = 3'd2,
    VERDICT_EMPTY_PRG = 3'd3,
    VERDICT_TRUNCATED = 3'd4,
    VERDICT_TRAILING  = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    MIRROR_HORIZONTAL  = 2'd0,
    MIRROR_VERTICAL    = 2'd1,
    MIRROR_FOUR_SCREEN = 2'd2
  } mirror_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      region;
    logic [OfsW-1:0] region_offset;
    logic [7:0]      byte_out;
    logic            done_res;
    logic [2:0]      verdict;
    logic [3:0]      mapper_number;
    logic [1:0]      mirroring;
    logic [RamW-1:0] prg_ram_bytes;
    logic [RamW-1:0] battery_ram_bytes;
    logic [RamW-1:0] chr_ram_bytes;
    logic [7:0]      prg_banks;
    logic [7:0]      chr_banks;
  } out_item_t;

endpackage

>>> src/iisp_tracker.sv
module iisp_tracker
  import iisp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            magic_ok_q, magic_ok_d;
  logic [7:0]      prg_q, prg_d;
  logic [7:0]      chr_q, chr_d;
  logic [7:0]      flags_q, flags_d;

  // Region boundaries, rebuilt every cycle from the latched header fields.
  logic [PosW-1:0] base_q, base_d;
  logic [PosW-1:0] prg_end_q, prg_end_d;
  logic [PosW-1:0] chr_end_q, chr_end_d;

  logic [PosW-1:0] ofs_base;
  logic [PosW-1:0] ofs_full;
  logic [PosW:0]   len;
  region_e         region;
  verdict_e        verdict;
  mirror_e         mirror;
  logic [3:0]      mapper;

  // Boundaries trail the header fields through base_q, prg_end_q and chr_end_q
  // in turn; the header is long done by the time any byte beyond it is classified.
  always_comb begin
    base_d    = flags_q[FlagTrainer] ? (HdrLen + TrainerLen) : HdrLen;
    prg_end_d = base_q + {1'b0, prg_q, 14'b0};
    chr_end_d = prg_end_q + {2'b0, chr_q, 13'b0};
  end

  // Header field latching and position count.
  always_comb begin
    pos_d      = pos_q;
    magic_ok_d = magic_ok_q;
    prg_d      = prg_q;
    chr_d      = chr_q;
    flags_d    = flags_q;
    if (pos_q < PosMagicEnd) begin
      if (item_i.data_byte != Magic[pos_q[1:0]]) begin
        magic_ok_d = 1'b0;
      end
    end
    if (pos_q == PosPrgBanks) begin
      prg_d = item_i.data_byte;
    end
    if (pos_q == PosChrBanks) begin
      chr_d = item_i.data_byte;
    end
    if (pos_q == PosFlags6) begin
      flags_d = item_i.data_byte;
    end
    if (pos_q != PosMax) begin
      pos_d = pos_q + 1'b1;
    end
  end

  // Region of the current byte and the start of that region.
  always_comb begin
    if (pos_q < HdrLen) begin
      region   = REGION_HEADER;
      ofs_base = '0;
    end else if (pos_q < base_q) begin
      region   = REGION_TRAINER;
      ofs_base = HdrLen;
    end else if (pos_q < prg_end_q) begin
      region   = REGION_PROGRAM;
      ofs_base = base_q;
    end else if (pos_q < chr_end_q) begin
      region   = REGION_CHARACTER;
      ofs_base = prg_end_q;
    end else begin
      region   = REGION_EXCESS;
      ofs_base = chr_end_q;
    end
    ofs_full = pos_q - ofs_base;
  end

  // Verdict on the last byte, in priority order.
  always_comb begin
    len = {1'b0, pos_q} + 1'b1;
    if (len < {1'b0, HdrLen}) begin
      verdict = VERDICT_SHORT;
    end else if (!magic_ok_d) begin
      verdict = VERDICT_BAD_MAGIC;
    end else if ({1'b0, prg_end_q} > len) begin
      verdict = VERDICT_TRUNCATED;
    end else if (prg_d == 8'd0) begin
      verdict = VERDICT_EMPTY_PRG;
    end else if ({1'b0, chr_end_q} > len) begin
      verdict = VERDICT_TRUNCATED;
    end else if ({1'b0, chr_end_q} != len) begin
      verdict = VERDICT_TRAILING;
    end else begin
      verdict = VERDICT_OK;
    end

    if (flags_d[FlagFourScreen]) begin
      mirror = MIRROR_FOUR_SCREEN;
    end else if (flags_d[FlagVertical]) begin
      mirror = MIRROR_VERTICAL;
    end else begin
      mirror = MIRROR_HORIZONTAL;
    end
    mapper = flags_d[7:4];
  end

  // Result item assembly; the descriptor is zero except on the last byte.
  always_comb begin
    result_o               = '0;
    result_o.region        = region;
    result_o.region_offset = ofs_full[PosW-1] ? {OfsW{1'b1}} : ofs_full[OfsW-1:0];
    result_o.byte_out      = item_i.data_byte;
    if (item_i.last_byte) begin
      result_o.done_res      = 1'b1;
      result_o.verdict       = verdict;
      result_o.mapper_number = mapper;
      result_o.mirroring     = mirror;
      if (mapper == MapperMmc1) begin
        result_o.prg_ram_bytes     = flags_d[FlagBattery] ? '0 : RamSize;
        result_o.battery_ram_bytes = flags_d[FlagBattery] ? RamSize : '0;
      end
      result_o.chr_ram_bytes = (chr_d == 8'd0) ? RamSize : '0;
      result_o.prg_banks     = prg_d;
      result_o.chr_banks     = chr_d;
    end
  end

  // Parser state; the last byte returns it to reset for the next image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      magic_ok_q <= 1'b1;
      prg_q      <= '0;
      chr_q      <= '0;
      flags_q    <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q      <= '0;
        magic_ok_q <= 1'b1;
        prg_q      <= '0;
        chr_q      <= '0;
        flags_q    <= '0;
      end else begin
        pos_q      <= pos_d;
        magic_ok_q <= magic_ok_d;
        prg_q      <= prg_d;
        chr_q      <= chr_d;
        flags_q    <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= HdrLen;
      prg_end_q <= HdrLen;
      chr_end_q <= HdrLen;
    end else begin
      base_q    <= base_d;
      prg_end_q <= prg_end_d;
      chr_end_q <= chr_end_d;
    end
  end

endmodule

>>> src/ines_image_stream_parser.sv
// Streaming parser for cartridge images in the iNES layout.
//
// Input channel: one image byte per item, with last_byte set on the final
// byte of the file. Output channel: one result item per input item, giving
// the byte's region and offset within it and the byte itself; the item for
// the last byte also carries the verdict and the cartridge descriptor.
//
// The input register feeds the parser logic, which loads the output
// register with the result. Throughput is one item per cycle while the
// receiver does not stall, set by the position counter and region compare.
//
// Reset clears the valid bits of both pipeline registers and returns the
// parser to the start of an image; the parser also restarts by itself after
// each last byte. When the receiver stalls, the result holds in the output
// register; an empty input register takes one more item before in_ready_o drops.
module ines_image_stream_parser
  import iisp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      out_free;
  logic      step;

  // Pipeline flow control.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  iisp_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_item_q),
    .result_o(result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> src/iisp_checker.sv
module iisp_checker
  import iisp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // Header bytes always sit at offsets below the header length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.region == REGION_HEADER)
    |-> (out_item_o.region_offset < 22'd16))
    else $error("header offset out of range");

  // Items that are not the last carry no verdict or descriptor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.done_res
    |-> (out_item_o.verdict == VERDICT_OK) && (out_item_o.prg_banks == 8'd0)
        && (out_item_o.chr_ram_bytes == '0) && (out_item_o.mapper_number == 4'd0))
    else $error("descriptor set on a non-final item");

  // An accepted image never has an empty program.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res && (out_item_o.verdict == VERDICT_OK)
    |-> (out_item_o.prg_banks != 8'd0))
    else $error("ok verdict with empty program");

endmodule

bind ines_image_stream_parser iisp_checker u_iisp_checker (.*);

>>> test/tb_ines_image_stream_parser.sv
`timescale 1ns / 1ps

module tb_ines_image_stream_parser;
  import iisp_pkg::*;

  localparam int unsigned PrgUnit  = 32'h4000;
  localparam int unsigned ChrUnit  = 32'h2000;
  localparam int unsigned OfsLimit = (1 << OfsW) - 1;
  localparam int unsigned ReportCap = 40;

  // Tracks the image layout byte by byte and holds the result items still due.
  class ines_layout_tracker;
    logic [PosW-1:0] byte_pos;
    bit              magic_good;
    logic [7:0]      prg_cnt;
    logic [7:0]      chr_cnt;
    logic [7:0]      flags6;
    out_item_t       due[$];
    int unsigned     mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      byte_pos   = '0;
      magic_good = 1'b1;
      prg_cnt    = '0;
      chr_cnt    = '0;
      flags6     = '0;
    endfunction

    // Works out the result item for one accepted byte.
    function void take_byte(in_item_t it);
      out_item_t   want;
      region_e     rgn;
      verdict_e    vd;
      mirror_e     mir;
      logic [3:0]  mapper;
      int unsigned p, base, prg, chr, q, ofs, len, prg_end, chr_end;
      want = '0;
      p = byte_pos;
      base = HdrLen + (flags6[FlagTrainer] ? TrainerLen : 0);
      prg = prg_cnt * PrgUnit;
      chr = chr_cnt * ChrUnit;

      // Region and offset use the header fields latched before this byte.
      if (p < HdrLen) begin
        rgn = REGION_HEADER;
        ofs = p;
      end else if (p < base) begin
        rgn = REGION_TRAINER;
        ofs = p - HdrLen;
      end else begin
        q = p - base;
        if (q < prg) begin
          rgn = REGION_PROGRAM;
          ofs = q;
        end else if (q - prg < chr) begin
          rgn = REGION_CHARACTER;
          ofs = q - prg;
        end else begin
          rgn = REGION_EXCESS;
          ofs = q - prg - chr;
        end
      end

      // Header capture.
      if (p < PosMagicEnd) begin
        if (it.data_byte != Magic[p]) magic_good = 1'b0;
      end else if (p == PosPrgBanks) begin
        prg_cnt = it.data_byte;
      end else if (p == PosChrBanks) begin
        chr_cnt = it.data_byte;
      end else if (p == PosFlags6) begin
        flags6 = it.data_byte;
      end

      if (byte_pos != PosMax) byte_pos++;

      want.region        = rgn;
      want.region_offset = OfsW'((ofs > OfsLimit) ? OfsLimit : ofs);
      want.byte_out      = it.data_byte;

      // The final byte of an image carries the verdict and the descriptor.
      if (it.last_byte) begin
        len = p + 1;
        base = HdrLen + (flags6[FlagTrainer] ? TrainerLen : 0);
        prg_end = base + prg_cnt * PrgUnit;
        chr_end = prg_end + chr_cnt * ChrUnit;
        if (len < HdrLen) vd = VERDICT_SHORT;
        else if (!magic_good) vd = VERDICT_BAD_MAGIC;
        else if (prg_end > len) vd = VERDICT_TRUNCATED;
        else if (prg_cnt == 0) vd = VERDICT_EMPTY_PRG;
        else if (chr_end > len) vd = VERDICT_TRUNCATED;
        else if (len != chr_end) vd = VERDICT_TRAILING;
        else vd = VERDICT_OK;
        if (flags6[FlagFourScreen]) mir = MIRROR_FOUR_SCREEN;
        else if (flags6[FlagVertical]) mir = MIRROR_VERTICAL;
        else mir = MIRROR_HORIZONTAL;
        mapper = flags6[7:4];
        want.done_res          = 1'b1;
        want.verdict           = vd;
        want.mapper_number     = mapper;
        want.mirroring         = mir;
        want.prg_ram_bytes     = (mapper == MapperMmc1 && !flags6[FlagBattery]) ? RamSize : '0;
        want.battery_ram_bytes = (mapper == MapperMmc1 && flags6[FlagBattery]) ? RamSize : '0;
        want.chr_ram_bytes     = (chr_cnt == 0) ? RamSize : '0;
        want.prg_banks         = prg_cnt;
        want.chr_banks         = chr_cnt;
        restart();
      end
      due.push_back(want);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (mismatches < ReportCap) $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one result item with the oldest one due.
    function void match_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        if (mismatches < ReportCap) $error("result item with no byte pending: %p", got);
        mismatches++;
        return;
      end
      want = due.pop_front();
      field_check("region", want.region, got.region);
      field_check("region_offset", want.region_offset, got.region_offset);
      field_check("byte_out", want.byte_out, got.byte_out);
      field_check("done_res", want.done_res, got.done_res);
      field_check("verdict", want.verdict, got.verdict);
      field_check("mapper_number", want.mapper_number, got.mapper_number);
      field_check("mirroring", want.mirroring, got.mirroring);
      field_check("prg_ram_bytes", want.prg_ram_bytes, got.prg_ram_bytes);
      field_check("battery_ram_bytes", want.battery_ram_bytes, got.battery_ram_bytes);
      field_check("chr_ram_bytes", want.chr_ram_bytes, got.chr_ram_bytes);
      field_check("prg_banks", want.prg_banks, got.prg_banks);
      field_check("chr_banks", want.chr_banks, got.chr_banks);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  ines_layout_tracker tracker;
  bit                 calm_run;
  int unsigned        stall_left;

  ines_image_stream_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_run) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: checks each accepted result item and stalls at random.
  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) tracker.match_result(out_item_o);
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    in_item_t    it;
    gap = idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.data_byte = b;
    it.last_byte = lst;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(it);
  endtask

  // Streams one image. A nonzero flaw corrupts that magic byte (1 to 4).
  task automatic send_image(input logic [7:0] prg_b, input logic [7:0] chr_b,
                            input logic [7:0] flags_b, input int unsigned flaw,
                            input int unsigned len, input bit force_calm);
    int unsigned i;
    logic [7:0]  b;
    calm_run = force_calm || ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) begin
      if (i < PosMagicEnd) b = Magic[i] ^ ((flaw == i + 1) ? 8'($urandom_range(1, 255)) : 8'h00);
      else if (i == PosPrgBanks) b = prg_b;
      else if (i == PosChrBanks) b = chr_b;
      else if (i == PosFlags6) b = flags_b;
      else b = 8'($urandom);
      send_byte(b, i == len - 1);
    end
  endtask

  function automatic logic [7:0] pick_banks();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'd0;
    if (r < 7) return 8'd1;
    if (r < 9) return 8'd2;
    return 8'($urandom);
  endfunction

  initial begin
    int unsigned filler_bytes;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    logic [7:0]  prg_b;
    logic [7:0]  chr_b;
    logic [7:0]  flags_b;
    tracker = new();
    calm_run = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short images, with the header fields latched so far.
    send_image(8'h00, 8'h00, 8'h00, 0, 1, 1'b0);
    send_image(8'h00, 8'h00, 8'h00, 1, 1, 1'b0);
    send_image(8'hFF, 8'h00, 8'h00, 0, 5, 1'b0);
    send_image(8'h01, 8'hAB, 8'h00, 0, 6, 1'b0);
    send_image(8'h02, 8'h03, 8'hFF, 0, 7, 1'b0);
    send_image(8'h01, 8'h01, 8'h10, 0, 15, 1'b0);
    // A bad magic byte at each of the four places.
    for (k = 1; k <= 4; k++) send_image(8'h01, 8'h00, 8'h00, k, 16, 1'b0);
    // Empty program, with and without a trainer.
    send_image(8'h00, 8'h00, 8'h00, 0, 16, 1'b0);
    send_image(8'h00, 8'h00, 8'h04, 0, 16, 1'b0);
    send_image(8'h00, 8'h00, 8'h04, 0, 600, 1'b0);
    // Descriptor variants on truncated images.
    send_image(8'hFF, 8'hFF, 8'h10, 0, 40, 1'b0);
    send_image(8'h01, 8'h00, 8'h12, 0, 40, 1'b0);
    send_image(8'h01, 8'h02, 8'h01, 0, 40, 1'b0);
    send_image(8'h01, 8'h02, 8'h09, 0, 40, 1'b0);

    // Random short images, mostly with good magic.
    filler_bytes = 0;
    while (filler_bytes < 960) begin
      prg_b = pick_banks();
      chr_b = pick_banks();
      flags_b = 8'($urandom);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
      r = $urandom_range(0, 9);
      if (r < 2) len = $urandom_range(1, 16);
      else if (r < 5) len = $urandom_range(17, 40);
      else len = $urandom_range(500, 560);
      send_image(prg_b, chr_b, flags_b, k, len, 1'b0);
      filler_bytes += len;
    end
    in_valid_i <= 1'b0;

    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
      $display("[ines_image_stream_parser] OK");
    end else begin
      $display("[ines_image_stream_parser] ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1_000_000_000;
    $display("[ines_image_stream_parser] ERROR");
    $finish;
  end

endmodule
